// ===== design/msbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// msbfr_pkg
// shared types and constants of the msb-first bit field reader
// ----------------------------------------------------------------------------
package msbfr_pkg;

  localparam int unsigned RESERVOIR_BITS_DEF = 128;
  localparam int unsigned MAX_READ_BITS_DEF  = 64;
  localparam int unsigned FIELD_W            = 64;
  localparam int unsigned COUNT_W            = 7;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned HELD_OUT_W         = 8;
  localparam int unsigned SIGNED_MAX_BITS    = 32;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

endpackage

// ===== design/msbfr_in_if.sv =====
// ----------------------------------------------------------------------------
// msbfr_in_if
// request channel: stream byte pushes and bit field reads
// ----------------------------------------------------------------------------
interface msbfr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [msbfr_pkg::BYTE_W-1:0]       byte_in;
  logic [msbfr_pkg::COUNT_W-1:0]      bit_count;
  logic                               signed_mode;

  modport source (output valid, kind, byte_in, bit_count, signed_mode, input ready);
  modport sink   (input valid, kind, byte_in, bit_count, signed_mode, output ready);
endinterface

// ===== design/msbfr_out_if.sv =====
// ----------------------------------------------------------------------------
// msbfr_out_if
// result channel: extracted field, status and fill level
// ----------------------------------------------------------------------------
interface msbfr_out_if;
  logic                                valid;
  logic                                ready;
  logic [msbfr_pkg::FIELD_W-1:0]       field_value;
  logic [1:0]                          status;
  logic [msbfr_pkg::HELD_OUT_W-1:0]    bits_held;

  modport source (output valid, field_value, status, bits_held, input ready);
  modport sink   (input valid, field_value, status, bits_held, output ready);
endinterface

// ===== design/msb_first_bit_field_reader_core.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader_core
// bit reservoir filled by bytes and emptied msb first by field reads
// ----------------------------------------------------------------------------
// in_i carries one beat per request: kind 0 appends byte_in to the reservoir,
// kind 1 reads bit_count bits (0..MAX_READ_BITS unsigned, 1..32 sign-magnitude
// when signed_mode is set) from the oldest end. out_o returns one beat per
// request with field_value, status and the bits left in the reservoir.
// a flagged request (full, too few bits, bad length) consumes nothing and
// returns a zero field.
// the input register loads at the accepting edge, the result register when that
// beat advances out of it, which a stall on out_o can delay.
// throughput: one request per cycle while out_o takes results; push and read
// each update the reservoir register in one step, by a shifted or or a left shift.
// reset empties the reservoir and drops any beat in flight.
// when out_o stalls, the result register holds and the input register takes
// one more beat; after that in_i.ready falls until out_o drains.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader_core #(
  parameter int unsigned RESERVOIR_BITS = msbfr_pkg::RESERVOIR_BITS_DEF,
  parameter int unsigned MAX_READ_BITS  = msbfr_pkg::MAX_READ_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  msbfr_in_if.sink        in_i,
  msbfr_out_if.source     out_o
);

  localparam int unsigned HELD_W = $clog2(RESERVOIR_BITS + 1);
  localparam int unsigned SUM_W  = $clog2(RESERVOIR_BITS + msbfr_pkg::BYTE_W + 1);
  localparam int unsigned FW     = msbfr_pkg::FIELD_W;
  localparam int unsigned CW     = msbfr_pkg::COUNT_W;
  localparam int unsigned BW     = msbfr_pkg::BYTE_W;
  localparam int unsigned OW     = msbfr_pkg::HELD_OUT_W;
  localparam int unsigned SH_W   = $clog2(msbfr_pkg::FIELD_W);

  // input register
  logic                    s1_valid_q;
  msbfr_pkg::kind_e        s1_kind_q;
  logic [BW-1:0]           s1_byte_q;
  logic [CW-1:0]           s1_count_q;
  logic                    s1_signed_q;
  logic                    s1_adv;

  // reservoir state, oldest bit at the top
  logic [RESERVOIR_BITS-1:0] res_q, res_d;
  logic [HELD_W-1:0]         held_q, held_d;

  // result register
  logic                          out_valid_q;
  logic [FW-1:0]                 value_q, value_d;
  msbfr_pkg::status_e            status_q, status_d;
  logic [msbfr_pkg::HELD_OUT_W-1:0] bits_held_q;

  logic                  full_f, bad_f, short_f;
  logic [FW-1:0]         top_win, raw, top_mask, mag;
  logic [SH_W-1:0]       top_sh;
  logic [RESERVOIR_BITS-1:0] push_bits;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_kind_q   <= msbfr_pkg::kind_e'(in_i.kind);
      s1_byte_q   <= in_i.byte_in;
      s1_count_q  <= in_i.bit_count;
      s1_signed_q <= in_i.signed_mode;
    end
  end

  // checks
  assign full_f  = (SUM_W'(held_q) + SUM_W'(BW)) > SUM_W'(RESERVOIR_BITS);
  assign bad_f   = s1_signed_q
                   ? (s1_count_q == '0 || s1_count_q > CW'(msbfr_pkg::SIGNED_MAX_BITS))
                   : (s1_count_q > CW'(MAX_READ_BITS));
  assign short_f = SUM_W'(s1_count_q) > SUM_W'(held_q);

  // field extraction
  assign top_win   = res_q[RESERVOIR_BITS-1 -: FW];
  assign raw       = top_win >> (CW'(FW) - s1_count_q);
  assign top_sh    = SH_W'(s1_count_q - CW'(1));
  assign top_mask  = FW'(1) << top_sh;
  assign mag       = raw & ~top_mask;
  assign push_bits = {s1_byte_q, {(RESERVOIR_BITS - BW){1'b0}}} >> held_q;

  always_comb begin
    res_d    = res_q;
    held_d   = held_q;
    value_d  = '0;
    status_d = msbfr_pkg::ST_OK;
    if (s1_kind_q == msbfr_pkg::KIND_PUSH) begin
      if (full_f) begin
        status_d = msbfr_pkg::ST_FULL;
      end else begin
        res_d  = res_q | push_bits;
        held_d = held_q + HELD_W'(BW);
      end
    end else begin
      if (bad_f) begin
        status_d = msbfr_pkg::ST_BADLEN;
      end else if (short_f) begin
        status_d = msbfr_pkg::ST_SHORT;
      end else begin
        res_d  = res_q << s1_count_q;
        held_d = held_q - HELD_W'(s1_count_q);
        if (s1_signed_q && (raw & top_mask) != '0) begin
          value_d = FW'(0) - mag;
        end else begin
          value_d = raw;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        res_q       <= res_d;
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      value_q     <= value_d;
      status_q    <= status_d;
      bits_held_q <= OW'(held_d);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.field_value = value_q;
  assign out_o.status      = status_q;
  assign out_o.bits_held   = bits_held_q;

  // assertions
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HELD_W'(RESERVOIR_BITS) >= held_q)
    else $error("reservoir fill level beyond capacity");

  a_clean_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q << held_q) == '0)
    else $error("stale bits past the valid region");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != msbfr_pkg::ST_OK |-> value_q == '0)
    else $error("flagged result with nonzero field");

  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_count_q) && $stable(held_q))
    else $error("input register lost a beat while stalled");

endmodule
